[sv/bod_pkg.sv]
// shared types, constants and helpers of the bass octaver
package bod_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_FRAC_BITS  = 16;
  localparam int STATE_BITS      = 32;
  localparam int WORD_BITS       = 48;
  localparam int DIGIT_BITS      = 4;
  localparam int MUL_DIGITS      = 5;
  localparam int MUL_A_BITS      = 40;
  localparam int MUL_C_BITS      = DIGIT_BITS * MUL_DIGITS;
  localparam int MUL_ACC_BITS    = MUL_A_BITS + MUL_C_BITS;
  localparam int MUL_P_BITS      = MUL_ACC_BITS - COEF_FRAC_BITS;
  localparam int CFG_IDX_BITS    = 8;
  localparam int CFG_DATA_BITS   = 18;

  localparam longint SQRT2_Q30 = 64'd1518500250;
  localparam longint SVF_R2 =
    (SQRT2_Q30 + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
  localparam longint BLK_POLE = (199 * (64'd1 << COEF_FRAC_BITS) + 100) / 200;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [STATE_BITS-1:0] state_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SUB1_GAIN  = 8'd0,
    REG_SUB2_GAIN  = 8'd1,
    REG_UP_GAIN    = 8'd2,
    REG_DRY_GAIN   = 8'd3,
    REG_ATTACK     = 8'd4,
    REG_RELEASE    = 8'd5,
    REG_SVF_G      = 8'd6,
    REG_SVF_H      = 8'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } st_e;

  typedef enum logic [3:0] {
    OP_T1,
    OP_HP,
    OP_G1,
    OP_G2,
    OP_ENV,
    OP_POLE,
    OP_S1,
    OP_S2,
    OP_UP,
    OP_DL,
    OP_DR
  } op_e;

  function automatic word_t sat_32(input word_t v);
    word_t hi;
    word_t lo;
    hi = word_t'(64'sh7FFF_FFFF);
    lo = -hi - word_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic word_t sat_40(input word_t v);
    word_t hi;
    word_t lo;
    hi = word_t'(64'sh7F_FFFF_FFFF);
    lo = -hi - word_t'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

[sv/bod_if.sv]
// stream and configuration channel interfaces
interface bod_in_if #(
  parameter int SAMPLE_BITS = bod_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface bod_out_if #(
  parameter int SAMPLE_BITS = bod_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface bod_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bod_pkg::CFG_IDX_BITS-1:0]   reg_idx;
  logic [bod_pkg::CFG_DATA_BITS-1:0]  wdata;
  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink (input valid, input reg_idx, input wdata, output ready);
endinterface

[sv/bod_mul.sv]
// digit-serial signed by unsigned multiplier with rounding to coefficient scale
module bod_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [bod_pkg::MUL_A_BITS-1:0]  a_i,
  input  logic [bod_pkg::MUL_C_BITS-1:0]         c_i,
  output logic                                   done_o,
  output logic signed [bod_pkg::MUL_P_BITS-1:0]  p_o
);

  localparam int AW = bod_pkg::MUL_A_BITS;
  localparam int CW = bod_pkg::MUL_C_BITS;
  localparam int DW = bod_pkg::DIGIT_BITS;
  localparam int SW = bod_pkg::MUL_ACC_BITS;
  localparam int FB = bod_pkg::COEF_FRAC_BITS;
  localparam int NW = $clog2(bod_pkg::MUL_DIGITS);
  localparam logic [NW-1:0] LAST = NW'(bod_pkg::MUL_DIGITS - 1);

  logic signed [AW-1:0] a_q;
  logic [CW-1:0]        c_q;
  logic signed [SW-1:0] acc_q, acc_d, rnd;
  logic signed [AW+DW:0] pp;
  logic [NW-1:0]        cnt_q;
  logic                 busy_q, done_q;

  assign pp    = a_q * $signed({1'b0, c_q[CW-1 -: DW]});
  assign acc_d = (acc_q <<< DW) + SW'(pp);
  assign rnd   = acc_q + (SW'(1) <<< (FB - 1));
  assign p_o   = rnd[SW-1:FB];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + NW'(1);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      c_q   <= c_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      c_q   <= c_q << DW;
    end
  end

endmodule

[sv/bass_octaver_divider_mix.sv]
// top level of the bass octaver with divider sub voices and stereo mix
// One stereo pair goes in and one comes out per item. All eleven products of an item run in
// turn through one shared multiplier that takes four coefficient bits a cycle, and a result
// is offered in the same cycle that the input is ready again; a new item is taken only once
// the last one is through the multiplier and its result has gone to the output register.
// The output register holds a result until it is taken while the next item is already in
// work. Configuration writes are always ready and take effect at once; write them only while
// no item is in work.
module bass_octaver_divider_mix #(
  parameter int SAMPLE_BITS = bod_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bod_in_if.sink    in_ch_i,
  bod_out_if.source out_ch_o,
  bod_cfg_if.sink   cfg_ch_i
);

  localparam int AW = bod_pkg::MUL_A_BITS;
  localparam int CW = bod_pkg::MUL_C_BITS;
  localparam int PW = bod_pkg::MUL_P_BITS;
  localparam int WW = bod_pkg::WORD_BITS;
  localparam bod_pkg::word_t OUT_MAX = (bod_pkg::word_t'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam bod_pkg::word_t OUT_MIN = -OUT_MAX - 1;
  localparam logic [CW-1:0] POLE_C = CW'(bod_pkg::BLK_POLE);
  localparam logic [CW-1:0] R2_C   = CW'(bod_pkg::SVF_R2);

  bod_pkg::st_e st_q, st_d;
  bod_pkg::op_e op_q, op_d;

  logic [17:0] sub1_q, sub2_q, up_q, dry_q;
  logic [15:0] att_q, rel_q;
  logic [16:0] g_q, h_q;

  bod_pkg::state_t i1_q, i1_d, i2_q, i2_d, prev_q, prev_d, env_q, env_d, bpo_q, bpo_d;
  logic signed [SAMPLE_BITS+1:0] bpi_q, bpi_d;
  logic half_q, half_d, quart_q, quart_d, par_q, par_d;

  logic signed [SAMPLE_BITS-1:0] xl_q, xl_d, xr_q, xr_d, ol_q, ol_d, or_q, or_d;
  logic signed [SAMPLE_BITS:0]   ax_q, ax_d;
  bod_pkg::word_t wet_q, wet_d;

  logic                 out_valid_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, ro_q;
  logic                 out_free, in_acc;

  logic                 mul_start, mul_done;
  logic signed [AW-1:0] mul_a;
  logic [CW-1:0]        mul_c;
  logic signed [PW-1:0] mul_p;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input bod_pkg::word_t v);
    if (v > OUT_MAX) return OUT_MAX[SAMPLE_BITS-1:0];
    if (v < OUT_MIN) return OUT_MIN[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  bod_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .c_i     (mul_c),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign in_ch_i.ready  = (st_q == bod_pkg::ST_IDLE);
  assign in_acc         = in_ch_i.valid && in_ch_i.ready;
  assign cfg_ch_i.ready = 1'b1;
  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.left_out  = lo_q;
  assign out_ch_o.right_out = ro_q;
  assign out_free = !out_valid_q || out_ch_o.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub1_q <= 18'd39321;
      sub2_q <= 18'd26214;
      up_q   <= 18'd0;
      dry_q  <= 18'd52429;
      att_q  <= 16'd65081;
      rel_q  <= 16'd65522;
      g_q    <= 17'd1073;
      h_q    <= 17'd64469;
    end else if (cfg_ch_i.valid) begin
      unique case (bod_pkg::cfg_reg_e'(cfg_ch_i.reg_idx))
        bod_pkg::REG_SUB1_GAIN: sub1_q <= cfg_ch_i.wdata;
        bod_pkg::REG_SUB2_GAIN: sub2_q <= cfg_ch_i.wdata;
        bod_pkg::REG_UP_GAIN:   up_q   <= cfg_ch_i.wdata;
        bod_pkg::REG_DRY_GAIN:  dry_q  <= cfg_ch_i.wdata;
        bod_pkg::REG_ATTACK:    att_q  <= cfg_ch_i.wdata[15:0];
        bod_pkg::REG_RELEASE:   rel_q  <= cfg_ch_i.wdata[15:0];
        bod_pkg::REG_SVF_G:     g_q    <= cfg_ch_i.wdata[16:0];
        bod_pkg::REG_SVF_H:     h_q    <= cfg_ch_i.wdata[16:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    op_d = op_q;
    unique case (st_q)
      bod_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_d = bod_pkg::ST_RUN;
          op_d = bod_pkg::OP_T1;
        end
      end
      bod_pkg::ST_RUN: begin
        if (mul_done) begin
          unique case (op_q)
            bod_pkg::OP_T1:   op_d = bod_pkg::OP_HP;
            bod_pkg::OP_HP:   op_d = bod_pkg::OP_G1;
            bod_pkg::OP_G1:   op_d = bod_pkg::OP_G2;
            bod_pkg::OP_G2:   op_d = bod_pkg::OP_ENV;
            bod_pkg::OP_ENV:  op_d = bod_pkg::OP_POLE;
            bod_pkg::OP_POLE: op_d = bod_pkg::OP_S1;
            bod_pkg::OP_S1:   op_d = bod_pkg::OP_S2;
            bod_pkg::OP_S2:   op_d = bod_pkg::OP_UP;
            bod_pkg::OP_UP:   op_d = bod_pkg::OP_DL;
            bod_pkg::OP_DL:   op_d = bod_pkg::OP_DR;
            bod_pkg::OP_DR:   st_d = bod_pkg::ST_HOLD;
            default:          op_d = bod_pkg::OP_T1;
          endcase
        end
      end
      bod_pkg::ST_HOLD: begin
        if (out_free) st_d = bod_pkg::ST_IDLE;
      end
      default: st_d = bod_pkg::ST_IDLE;
    endcase
  end

  // datapath and multiplier sequencing
  always_comb begin
    bod_pkg::word_t pw, hp0, hpv, bpv, lpv, envv, yv, diff, ax_w, sgn;
    i1_d = i1_q; i2_d = i2_q; prev_d = prev_q; env_d = env_q;
    bpo_d = bpo_q; bpi_d = bpi_q;
    half_d = half_q; quart_d = quart_q; par_d = par_q;
    xl_d = xl_q; xr_d = xr_q; ax_d = ax_q; ol_d = ol_q; or_d = or_q;
    wet_d = wet_q;
    mul_start = 1'b0;
    mul_a = '0;
    mul_c = '0;
    pw   = WW'(mul_p);
    ax_w = WW'(ax_q);
    hp0 = '0; hpv = '0; bpv = '0; lpv = '0; envv = '0; yv = '0; diff = '0; sgn = '0;
    if (in_acc) begin
      xl_d = in_ch_i.left_in;
      xr_d = in_ch_i.right_in;
      ax_d = in_ch_i.left_in[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(in_ch_i.left_in)
                                            : (SAMPLE_BITS+1)'(in_ch_i.left_in);
      mul_start = 1'b1;
      mul_a = AW'(i1_q);
      mul_c = R2_C + CW'(g_q);
    end else if (st_q == bod_pkg::ST_RUN && mul_done) begin
      unique case (op_q)
        bod_pkg::OP_T1: begin
          hp0 = bod_pkg::sat_40(WW'(xl_q) - pw - WW'(i2_q));
          mul_start = 1'b1;
          mul_a = hp0[AW-1:0];
          mul_c = CW'(h_q);
        end
        bod_pkg::OP_HP: begin
          hpv = bod_pkg::sat_32(pw);
          mul_start = 1'b1;
          mul_a = hpv[AW-1:0];
          mul_c = CW'(g_q);
        end
        bod_pkg::OP_G1: begin
          bpv = bod_pkg::sat_32(pw + WW'(i1_q));
          i1_d = bod_pkg::state_t'(bod_pkg::sat_32(pw + bpv));
          mul_start = 1'b1;
          mul_a = bpv[AW-1:0];
          mul_c = CW'(g_q);
        end
        bod_pkg::OP_G2: begin
          lpv = bod_pkg::sat_32(pw + WW'(i2_q));
          i2_d = bod_pkg::state_t'(bod_pkg::sat_32(pw + lpv));
          prev_d = bod_pkg::state_t'(lpv);
          if (prev_q <= 0 && lpv > 0) begin
            half_d = !half_q;
            if (par_q) begin
              quart_d = !quart_q;
              par_d = 1'b0;
            end else begin
              par_d = 1'b1;
            end
          end
          diff = WW'(env_q) - ax_w;
          mul_start = 1'b1;
          mul_a = diff[AW-1:0];
          mul_c = (ax_w > WW'(env_q)) ? CW'(att_q) : CW'(rel_q);
        end
        bod_pkg::OP_ENV: begin
          envv = bod_pkg::sat_32(ax_w + pw);
          env_d = bod_pkg::state_t'(envv);
          mul_start = 1'b1;
          mul_a = AW'(bpo_q);
          mul_c = POLE_C;
        end
        bod_pkg::OP_POLE: begin
          yv = bod_pkg::sat_32((ax_w <<< 1) - WW'(bpi_q) + pw);
          bpi_d = (SAMPLE_BITS+2)'(ax_w <<< 1);
          bpo_d = bod_pkg::state_t'(yv);
          wet_d = '0;
          sgn = half_q ? WW'(env_q) : -WW'(env_q);
          mul_start = 1'b1;
          mul_a = sgn[AW-1:0];
          mul_c = CW'(sub1_q);
        end
        bod_pkg::OP_S1: begin
          wet_d = wet_q + pw;
          sgn = quart_q ? WW'(env_q) : -WW'(env_q);
          mul_start = 1'b1;
          mul_a = sgn[AW-1:0];
          mul_c = CW'(sub2_q);
        end
        bod_pkg::OP_S2: begin
          wet_d = wet_q + pw;
          mul_start = 1'b1;
          mul_a = AW'(bpo_q);
          mul_c = CW'(up_q);
        end
        bod_pkg::OP_UP: begin
          wet_d = wet_q + pw;
          mul_start = 1'b1;
          mul_a = AW'(xl_q);
          mul_c = CW'(dry_q);
        end
        bod_pkg::OP_DL: begin
          ol_d = sat_out(pw + wet_q);
          mul_start = 1'b1;
          mul_a = AW'(xr_q);
          mul_c = CW'(dry_q);
        end
        bod_pkg::OP_DR: begin
          or_d = sat_out(pw + wet_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bod_pkg::ST_IDLE;
      op_q <= bod_pkg::OP_T1;
      i1_q <= '0; i2_q <= '0; prev_q <= '0; env_q <= '0;
      bpo_q <= '0; bpi_q <= '0;
      half_q <= 1'b0; quart_q <= 1'b0; par_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      op_q <= op_d;
      i1_q <= i1_d; i2_q <= i2_d; prev_q <= prev_d; env_q <= env_d;
      bpo_q <= bpo_d; bpi_q <= bpi_d;
      half_q <= half_d; quart_q <= quart_d; par_q <= par_d;
      if (st_q == bod_pkg::ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xl_q <= xl_d; xr_q <= xr_d; ax_q <= ax_d;
    ol_q <= ol_d; or_q <= or_d;
    wet_q <= wet_d;
    if (st_q == bod_pkg::ST_HOLD && out_free) begin
      lo_q <= ol_q;
      ro_q <= or_q;
    end
  end

endmodule

[sv/bod_chk.sv]
// port-level checks of the bass octaver, bound to the top level
module bod_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_ready_i
);

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while previous item in work");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result offered straight after input transfer");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before transfer");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port stalled");

endmodule

bind bass_octaver_divider_mix bod_chk u_bod_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .cfg_ready_i (cfg_ch_i.ready)
);

[test/tb_bass_octaver_divider_mix.sv]
// self-checking testbench of the bass octaver with divider sub voices and stereo mix
`timescale 1ns / 100ps

module tb_bass_octaver_divider_mix;

  localparam int SB = bod_pkg::SAMPLE_BITS_DEF;
  localparam logic [bod_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 8'd200;
  localparam longint CYCLE_LIMIT = 600000;
  localparam longint S_MAX = 64'sd8388607;
  localparam longint S_MIN = -64'sd8388608;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bod_in_if  in_ch ();
  bod_out_if out_ch ();
  bod_cfg_if cfg_ch ();

  bass_octaver_divider_mix uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .cfg_ch_i(cfg_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirrored registers and state
  longint m_sub1, m_sub2, m_up, m_dry, m_att, m_rel, m_g, m_h;
  longint s_int1, s_int2, s_prev_lp, s_env, s_blk_in, s_blk_out;
  bit s_half, s_quarter, s_parity;

  pair_t mix_q[$];
  int errors = 0;
  longint cycles = 0;
  int hold_len = 0;

  function automatic longint coef_mul(input longint a, input longint c);
    return (a * c + (64'sd1 <<< (bod_pkg::COEF_FRAC_BITS - 1))) >>> bod_pkg::COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic reset_mirror();
    m_sub1 = 39321; m_sub2 = 26214; m_up = 0; m_dry = 52429;
    m_att = 65081; m_rel = 65522; m_g = 1073; m_h = 64469;
    s_int1 = 0; s_int2 = 0; s_prev_lp = 0; s_env = 0; s_blk_in = 0; s_blk_out = 0;
    s_half = 0; s_quarter = 0; s_parity = 0;
  endtask

  function automatic pair_t octaver_mix(input pair_t x);
    longint xl, xr, r2, pole, hp, bp, lp, ax, k, y, s1w, s2w, wet;
    pair_t o;
    xl = longint'(x.left);
    xr = longint'(x.right);
    r2 = bod_pkg::SVF_R2;
    pole = bod_pkg::BLK_POLE;
    hp = xl - coef_mul(s_int1, r2 + m_g) - s_int2;
    hp = clamp(coef_mul(clamp(hp, 40), m_h), 32);
    bp = clamp(coef_mul(hp, m_g) + s_int1, 32);
    s_int1 = clamp(coef_mul(hp, m_g) + bp, 32);
    lp = clamp(coef_mul(bp, m_g) + s_int2, 32);
    s_int2 = clamp(coef_mul(bp, m_g) + lp, 32);
    if (s_prev_lp <= 0 && lp > 0) begin
      s_half = !s_half;
      if (s_parity) begin
        s_quarter = !s_quarter;
        s_parity = 0;
      end else begin
        s_parity = 1;
      end
    end
    s_prev_lp = lp;
    ax = xl < 0 ? -xl : xl;
    k = (ax > s_env) ? m_att : m_rel;
    s_env = clamp(ax + coef_mul(s_env - ax, k), 32);
    s1w = s_half ? s_env : -s_env;
    s2w = s_quarter ? s_env : -s_env;
    y = clamp(2 * ax - s_blk_in + coef_mul(s_blk_out, pole), 32);
    s_blk_in = 2 * ax;
    s_blk_out = y;
    wet = coef_mul(s1w, m_sub1) + coef_mul(s2w, m_sub2) + coef_mul(y, m_up);
    o.left = SB'(clamp(coef_mul(xl, m_dry) + wet, SB));
    o.right = SB'(clamp(coef_mul(xr, m_dry) + wet, SB));
    return o;
  endfunction

  task automatic write_reg(input logic [bod_pkg::CFG_IDX_BITS-1:0] idx, input longint val);
    logic [bod_pkg::CFG_DATA_BITS-1:0] d;
    d = bod_pkg::CFG_DATA_BITS'(val);
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata <= d;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      bod_pkg::REG_SUB1_GAIN: m_sub1 = d;
      bod_pkg::REG_SUB2_GAIN: m_sub2 = d;
      bod_pkg::REG_UP_GAIN:   m_up = d;
      bod_pkg::REG_DRY_GAIN:  m_dry = d;
      bod_pkg::REG_ATTACK:    m_att = d[15:0];
      bod_pkg::REG_RELEASE:   m_rel = d[15:0];
      bod_pkg::REG_SVF_G:     m_g = d[16:0];
      bod_pkg::REG_SVF_H:     m_h = d[16:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input longint s1, s2, up, dry, att, rel, g, h);
    write_reg(bod_pkg::REG_SUB1_GAIN, s1);
    write_reg(bod_pkg::REG_SUB2_GAIN, s2);
    write_reg(bod_pkg::REG_UP_GAIN, up);
    write_reg(bod_pkg::REG_DRY_GAIN, dry);
    write_reg(bod_pkg::REG_ATTACK, att);
    write_reg(bod_pkg::REG_RELEASE, rel);
    write_reg(bod_pkg::REG_SVF_G, g);
    write_reg(bod_pkg::REG_SVF_H, h);
  endtask

  // valid stays high across back-to-back items; lowered only before a gap
  task automatic send_pair(input longint l, input longint r);
    int gap;
    pair_t x;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    x.left = SB'(l);
    x.right = SB'(r);
    in_ch.left_in <= x.left;
    in_ch.right_in <= x.right;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    mix_q.insert(mix_q.size(), octaver_mix(x));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (mix_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic longint rand_sample();
    return longint'($signed(SB'($urandom)));
  endfunction

  // periodic waveform with random period, amplitude and noise
  task automatic send_tone(input int n);
    int period, kind;
    longint amp, v, nz;
    period = $urandom_range(6, 60);
    kind = $urandom_range(0, 2);
    amp = $urandom_range(1000, 8388607);
    nz = $urandom_range(0, 2000);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = ((i % period) < period / 2) ? amp : -amp;
        1: v = -amp + (2 * amp * (i % period)) / period;
        default: v = ((i % period) < period / 2) ?
          -amp + (4 * amp * (i % period)) / period :
          3 * amp - (4 * amp * (i % period)) / period;
      endcase
      v = clamp(v + longint'($urandom_range(0, 2 * nz)) - nz, SB);
      send_pair(v, $urandom_range(0, 1) ? rand_sample() : v);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample());
  endtask

  task automatic test_directed_defaults();
    send_pair(0, 0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(-1, 1);
    for (int i = 0; i < 6; i++) send_pair(i % 2 ? S_MIN : S_MAX, 0);
    drain();
  endtask

  task automatic test_directed_extremes();
    // every gain at full scale so the outputs saturate
    write_all(262143, 262143, 262143, 262143, 65535, 65535, 131071, 65536);
    write_reg(REG_UNUSED, 12345);
    for (int i = 0; i < 6; i++) send_pair(i % 2 ? S_MIN : S_MAX, i % 3 ? S_MAX : S_MIN);
    drain();
    // out-of-range coefficients saturate the filter
    write_all(0, 0, 0, 0, 0, 0, 262143, 262143);
    for (int i = 0; i < 6; i++) send_pair(i % 2 ? S_MIN : S_MAX, rand_sample());
    drain();
  endtask

  task automatic test_tracking();
    write_all(39321, 26214, 30000, 52429, 60000, 65000, 8192, 54960);
    for (int i = 0; i < 4; i++) send_tone(40);
    drain();
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 4; p++) begin
      write_all($urandom_range(0, 262143), $urandom_range(0, 262143),
                $urandom_range(0, 262143), $urandom_range(0, 262143),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(500, 20000), $urandom_range(30000, 65536));
      send_tone(45);
      send_noise(10);
      send_tone(20);
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_all(39321, 26214, 20000, 52429, 65081, 65522, 6000, 57000);
    hold_len = 400;
    send_tone(30);
    drain();
  endtask

  task automatic test_low_gains();
    write_all(1, 0, 1, 65536, 1, 0, 1, 1);
    send_noise(10);
    send_tone(20);
    drain();
    write_all(39321, 26214, 0, 52429, 65081, 65522, 1073, 64469);
    send_tone(40);
    drain();
  endtask

  // receiver: random stall per item, one long hold-off on request
  initial begin
    int w;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_len > 0) begin
        w = hold_len;
        hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      w = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    pair_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (mix_q.size() == 0) begin
        $display("%0t: result with none expected: %0d %0d", $time,
                 out_ch.left_out, out_ch.right_out);
        errors++;
      end else begin
        e = mix_q.pop_front();
        if (out_ch.left_out !== e.left) begin
          $display("%0t: left_out expected %0d actual %0d", $time, e.left, out_ch.left_out);
          errors++;
        end
        if (out_ch.right_out !== e.right) begin
          $display("%0t: right_out expected %0d actual %0d", $time, e.right,
                   out_ch.right_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.left_in <= '0;
    in_ch.right_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_idx <= '0;
    cfg_ch.wdata <= '0;
    reset_mirror();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_directed_extremes();
    test_tracking();
    test_random_settings();
    test_backpressure();
    test_low_gains();
    if (mix_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
